// ===== src/tbo_pkg.sv =====
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants for the triangle / box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int HALF_WIDTH      = 23;
   localparam int CSR_IDX_WIDTH   = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HALF_X = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HALF_Y = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HALF_Z = 2'd2;

   localparam logic [HALF_WIDTH-1:0] HALF_RESET = 23'd2048;

   typedef logic [HALF_WIDTH-1:0] half_type;

endpackage

`default_nettype wire

// ===== src/tbo_plane.sv =====
// ----------------------------------------------------------------------------
// tbo_plane
// Six-stage pipeline for the triangle plane against the box: normal, split,
// partial products, dot products, and the final window compare.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_plane #(
   parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF
) (
   input  wire                                   clock,
   input  wire  signed [COORD_WIDTH+1:0]         edge0 [3],
   input  wire  signed [COORD_WIDTH+1:0]         edge1 [3],
   input  wire  signed [COORD_WIDTH:0]           vert0 [3],
   input  tbo_pkg::half_type                     half  [3],
   output logic                                  plane_ok
);
   import tbo_pkg::*;

   localparam int VW  = COORD_WIDTH + 1;
   localparam int EW  = COORD_WIDTH + 2;
   localparam int NW  = 2 * EW + 1;
   localparam int LOW = (NW + 1) / 2;
   localparam int HIW = NW - LOW;
   localparam int CW  = NW + VW + HALF_WIDTH + 4;

   logic signed [2*EW-1:0]         na_ff [3];
   logic signed [2*EW-1:0]         nb_ff [3];
   logic signed [VW-1:0]           v3_ff [3];
   logic signed [NW-1:0]           n_ff  [3];
   logic signed [VW-1:0]           v4_ff [3];
   logic [LOW-1:0]                 nl_ff [3];
   logic signed [HIW-1:0]          nh_ff [3];
   logic [LOW-1:0]                 ml_ff [3];
   logic [HIW-1:0]                 mh_ff [3];
   logic signed [VW-1:0]           v5_ff [3];
   logic signed [LOW+VW:0]         dl_ff [3];
   logic signed [HIW+VW-1:0]       dh_ff [3];
   logic [LOW+HALF_WIDTH-1:0]      rl_ff [3];
   logic [HIW+HALF_WIDTH-1:0]      rh_ff [3];
   logic signed [CW-1:0]           d_ff;
   logic signed [CW-1:0]           r_ff;
   logic                           ok_ff;

   logic signed [CW-1:0]           d_in;
   logic signed [CW-1:0]           r_in;
   logic [NW-1:0]                  mag [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mag[c] = n_ff[c][NW-1] ? NW'(-n_ff[c]) : NW'(n_ff[c]);
      end
   end

   always_comb begin
      logic signed [CW-1:0] t_hi;
      logic signed [CW-1:0] t_lo;
      logic signed [CW-1:0] u_hi;
      logic signed [CW-1:0] u_lo;
      d_in = '0;
      r_in = '0;
      for (int c = 0; c < 3; c++) begin
         t_hi = CW'(dh_ff[c]);
         t_lo = CW'(dl_ff[c]);
         u_hi = CW'(rh_ff[c]);
         u_lo = CW'(rl_ff[c]);
         d_in = d_in + (t_hi <<< LOW) + t_lo;
         r_in = r_in + (u_hi <<< LOW) + u_lo;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         na_ff[c] <= edge0[(c+1)%3] * edge1[(c+2)%3];
         nb_ff[c] <= edge0[(c+2)%3] * edge1[(c+1)%3];
         v3_ff[c] <= vert0[c];
         n_ff[c]  <= NW'(na_ff[c]) - NW'(nb_ff[c]);
         v4_ff[c] <= v3_ff[c];
         nl_ff[c] <= n_ff[c][LOW-1:0];
         nh_ff[c] <= n_ff[c][NW-1:LOW];
         ml_ff[c] <= mag[c][LOW-1:0];
         mh_ff[c] <= mag[c][NW-1:LOW];
         v5_ff[c] <= v4_ff[c];
         dl_ff[c] <= $signed({1'b0, nl_ff[c]}) * v5_ff[c];
         dh_ff[c] <= nh_ff[c] * v5_ff[c];
         rl_ff[c] <= ml_ff[c] * half[c];
         rh_ff[c] <= mh_ff[c] * half[c];
      end
      d_ff  <= d_in;
      r_ff  <= r_in;
      ok_ff <= (d_ff <= r_ff) && (d_ff >= -r_ff);
   end

   assign plane_ok = ok_ff;

endmodule

`default_nettype wire

// ===== src/triangle_box_overlap_test_top.sv =====
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_top
// Separating-axis overlap test of one triangle against an axis-aligned box.
// ----------------------------------------------------------------------------
// A request (three vertices and a box centre, signed Q12.12) is taken at
// each rising edge where start is high and busy is low; busy is always low,
// so one request may be issued every cycle.
// The box half extents live in three registers written through the csr_
// channel (index 0, 1, 2 for x, y, z); csr_ready is always high. Write them
// only while no request is in flight.
// Each request gives one result: rsp_valid is high for one cycle with
// rsp_overlaps (1 on overlap or touch). The receiver cannot stall;
// results follow request order, one per cycle. Throughput is one
// request per cycle; the pipeline depth is set by the plane test path
// (two multiply stages for the normal and the dot product with the
// split normal, plus add and compare stages).
// Reset clears the pipeline valid bits and loads 0.5 into every half extent.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_box_overlap_test_top #(
   parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert0_x,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert0_y,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert0_z,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert1_x,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert1_y,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert1_z,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert2_x,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert2_y,
   input  wire  signed [COORD_WIDTH-1:0]         req_vert2_z,
   input  wire  signed [COORD_WIDTH-1:0]         req_center_x,
   input  wire  signed [COORD_WIDTH-1:0]         req_center_y,
   input  wire  signed [COORD_WIDTH-1:0]         req_center_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_overlaps,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [tbo_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  wire  [tbo_pkg::HALF_WIDTH-1:0]        csr_wdata
);
   import tbo_pkg::*;

   localparam int VW   = COORD_WIDTH + 1;
   localparam int EW   = COORD_WIDTH + 2;
   localparam int MW   = EW + VW;
   localparam int PW   = MW + 1;
   localparam int RADW = EW + HALF_WIDTH + 1;
   localparam int QW   = PW + HALF_WIDTH + 2;
   localparam int BW   = ((VW > HALF_WIDTH) ? VW : HALF_WIDTH) + 2;

   half_type                     half_ff [3];
   logic [7:0]                   valid_ff;
   logic signed [VW-1:0]         v_in  [3][3];
   logic signed [VW-1:0]         v1_ff [3][3];
   logic signed [VW-1:0]         v2_ff [3][3];
   logic signed [EW-1:0]         e2_ff [3][3];
   logic                         box_in;
   logic [2:0]                   box_ff;
   logic signed [MW-1:0]         pa_ff [3][3][3];
   logic signed [MW-1:0]         pb_ff [3][3][3];
   logic [EW+HALF_WIDTH-1:0]     ra_ff [3][3];
   logic [EW+HALF_WIDTH-1:0]     rb_ff [3][3];
   logic [EW-1:0]                eabs  [3][3];
   logic signed [PW-1:0]         p_ff  [3][3][3];
   logic [RADW-1:0]              rad_ff [3][3];
   logic                         edge_in;
   logic [3:0]                   edge_ff;
   logic                         plane_ok;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= HALF_RESET;
         half_ff[1] <= HALF_RESET;
         half_ff[2] <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_X: half_ff[0] <= csr_wdata;
            CSR_HALF_Y: half_ff[1] <= csr_wdata;
            CSR_HALF_Z: half_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[6:0], start && !busy};
      end
   end

   // translate to the box centre
   always_comb begin
      v_in[0][0] = VW'(req_vert0_x) - VW'(req_center_x);
      v_in[0][1] = VW'(req_vert0_y) - VW'(req_center_y);
      v_in[0][2] = VW'(req_vert0_z) - VW'(req_center_z);
      v_in[1][0] = VW'(req_vert1_x) - VW'(req_center_x);
      v_in[1][1] = VW'(req_vert1_y) - VW'(req_center_y);
      v_in[1][2] = VW'(req_vert1_z) - VW'(req_center_z);
      v_in[2][0] = VW'(req_vert2_x) - VW'(req_center_x);
      v_in[2][1] = VW'(req_vert2_y) - VW'(req_center_y);
      v_in[2][2] = VW'(req_vert2_z) - VW'(req_center_z);
   end

   always_comb begin
      logic signed [BW-1:0] a;
      logic signed [BW-1:0] b;
      logic signed [BW-1:0] d;
      logic signed [BW-1:0] h;
      box_in = 1'b1;
      for (int c = 0; c < 3; c++) begin
         a = BW'(v1_ff[0][c]);
         b = BW'(v1_ff[1][c]);
         d = BW'(v1_ff[2][c]);
         h = BW'(half_ff[c]);
         if ((a > h && b > h && d > h) || (a < -h && b < -h && d < -h)) begin
            box_in = 1'b0;
         end
      end
   end

   always_comb begin
      for (int t = 0; t < 3; t++) begin
         for (int c = 0; c < 3; c++) begin
            eabs[t][c] = e2_ff[t][c][EW-1] ? EW'(-e2_ff[t][c]) : EW'(e2_ff[t][c]);
         end
      end
   end

   always_comb begin
      logic signed [QW-1:0] p0;
      logic signed [QW-1:0] p1;
      logic signed [QW-1:0] p2;
      logic signed [QW-1:0] r;
      edge_in = box_ff[2];
      for (int t = 0; t < 3; t++) begin
         for (int i = 0; i < 3; i++) begin
            p0 = QW'(p_ff[t][i][0]);
            p1 = QW'(p_ff[t][i][1]);
            p2 = QW'(p_ff[t][i][2]);
            r  = QW'(rad_ff[t][i]);
            if ((p0 > r && p1 > r && p2 > r) || (p0 < -r && p1 < -r && p2 < -r)) begin
               edge_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff  <= {box_ff[1:0], box_in};
      edge_ff <= {edge_ff[2:0], edge_in};
      for (int t = 0; t < 3; t++) begin
         for (int c = 0; c < 3; c++) begin
            v1_ff[t][c] <= v_in[t][c];
            v2_ff[t][c] <= v1_ff[t][c];
            e2_ff[t][c] <= EW'(v1_ff[(t+1)%3][c]) - EW'(v1_ff[t][c]);
         end
      end
      for (int t = 0; t < 3; t++) begin
         for (int i = 0; i < 3; i++) begin
            for (int u = 0; u < 3; u++) begin
               pa_ff[t][i][u] <= e2_ff[t][(i+2)%3] * v2_ff[u][(i+1)%3];
               pb_ff[t][i][u] <= e2_ff[t][(i+1)%3] * v2_ff[u][(i+2)%3];
               p_ff[t][i][u]  <= PW'(pa_ff[t][i][u]) - PW'(pb_ff[t][i][u]);
            end
            ra_ff[t][i]  <= eabs[t][(i+2)%3] * half_ff[(i+1)%3];
            rb_ff[t][i]  <= eabs[t][(i+1)%3] * half_ff[(i+2)%3];
            rad_ff[t][i] <= RADW'(ra_ff[t][i]) + RADW'(rb_ff[t][i]);
         end
      end
   end

   tbo_plane #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_plane (
      .clock    (clock),
      .edge0    (e2_ff[0]),
      .edge1    (e2_ff[1]),
      .vert0    (v2_ff[0]),
      .half     (half_ff),
      .plane_ok (plane_ok)
   );

   assign rsp_valid    = valid_ff[7];
   assign rsp_overlaps = edge_ff[3] & plane_ok;

endmodule

`default_nettype wire

// ===== src/tbo_checker.sv =====
// ----------------------------------------------------------------------------
// tbo_checker
// Port-level request-to-result timing and centre-point overlap checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_checker #(
   parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH_DEF
) (
   input wire                            clock,
   input wire                            reset,
   input wire                            start,
   input wire                            busy,
   input wire signed [COORD_WIDTH-1:0]   req_vert0_x,
   input wire signed [COORD_WIDTH-1:0]   req_vert0_y,
   input wire signed [COORD_WIDTH-1:0]   req_vert0_z,
   input wire signed [COORD_WIDTH-1:0]   req_vert1_x,
   input wire signed [COORD_WIDTH-1:0]   req_vert1_y,
   input wire signed [COORD_WIDTH-1:0]   req_vert1_z,
   input wire signed [COORD_WIDTH-1:0]   req_vert2_x,
   input wire signed [COORD_WIDTH-1:0]   req_vert2_y,
   input wire signed [COORD_WIDTH-1:0]   req_vert2_z,
   input wire signed [COORD_WIDTH-1:0]   req_center_x,
   input wire signed [COORD_WIDTH-1:0]   req_center_y,
   input wire signed [COORD_WIDTH-1:0]   req_center_z,
   input wire                            rsp_valid,
   input wire                            rsp_overlaps
);

   logic at_centre;

   assign at_centre = req_vert0_x == req_center_x && req_vert0_y == req_center_y &&
                      req_vert0_z == req_center_z && req_vert1_x == req_center_x &&
                      req_vert1_y == req_center_y && req_vert1_z == req_center_z &&
                      req_vert2_x == req_center_x && req_vert2_y == req_center_y &&
                      req_vert2_z == req_center_z;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_valid)
      else $error("result missing eight cycles after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 8))
      else $error("result without matching request");

   a_point_inside: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && at_centre) |-> ##8 (rsp_valid && rsp_overlaps))
      else $error("point at box centre reported as apart");

endmodule

bind triangle_box_overlap_test_top tbo_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_tbo_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_vert0_x  (req_vert0_x),
   .req_vert0_y  (req_vert0_y),
   .req_vert0_z  (req_vert0_z),
   .req_vert1_x  (req_vert1_x),
   .req_vert1_y  (req_vert1_y),
   .req_vert1_z  (req_vert1_z),
   .req_vert2_x  (req_vert2_x),
   .req_vert2_y  (req_vert2_y),
   .req_vert2_z  (req_vert2_z),
   .req_center_x (req_center_x),
   .req_center_y (req_center_y),
   .req_center_z (req_center_z),
   .rsp_valid    (rsp_valid),
   .rsp_overlaps (rsp_overlaps)
);

`default_nettype wire

// ===== verif/triangle_box_overlap_test_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_top_test
// Self-checking bench for the triangle / box separating-axis overlap test.
// ----------------------------------------------------------------------------
// Triangles and box centres are streamed with random gaps. Each accepted
// request is predicted in exact 128-bit arithmetic and the expected overlap
// flag is queued. Each result strobe is checked against the oldest flag.
// The half extents are rewritten between phases, covering zero, maximum,
// random sizes and a write to the unused register index.
// ----------------------------------------------------------------------------

class overlap_board;
   bit expected_overlaps[$];
   int mismatches;
   int failures;

   function void note_request(bit flag);
      expected_overlaps.push_back(flag);
   endfunction

   function void check_result(bit actual);
      bit want;
      if (expected_overlaps.size() == 0) begin
         failures++;
         $display("unexpected result: overlaps=%0b", actual);
         return;
      end
      want = expected_overlaps.pop_front();
      if (want !== actual) begin
         failures++;
         mismatches++;
         if (mismatches <= 10)
            $display("overlaps mismatch: expected %0b actual %0b", want, actual);
      end
   endfunction
endclass

module triangle_box_overlap_test_top_test;
   import tbo_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int NFIELD    = 12;
   localparam int LATENCY   = 8;
   localparam int MAX_CYCLE = 400000;

   typedef logic signed [127:0] wide_t;
   typedef logic [NFIELD*CW-1:0] tri_flat_t;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      rsp_valid;
   logic                      rsp_overlaps;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [HALF_WIDTH-1:0]     csr_wdata;
   tri_flat_t                 req_fields;

   half_type half_size [3];
   overlap_board board;
   int cycle_count = 0;
   bit no_idle;

   triangle_box_overlap_test_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_vert0_x  (req_fields[0*CW +: CW]),
      .req_vert0_y  (req_fields[1*CW +: CW]),
      .req_vert0_z  (req_fields[2*CW +: CW]),
      .req_vert1_x  (req_fields[3*CW +: CW]),
      .req_vert1_y  (req_fields[4*CW +: CW]),
      .req_vert1_z  (req_fields[5*CW +: CW]),
      .req_vert2_x  (req_fields[6*CW +: CW]),
      .req_vert2_y  (req_fields[7*CW +: CW]),
      .req_vert2_z  (req_fields[8*CW +: CW]),
      .req_center_x (req_fields[9*CW +: CW]),
      .req_center_y (req_fields[10*CW +: CW]),
      .req_center_z (req_fields[11*CW +: CW]),
      .rsp_valid    (rsp_valid),
      .rsp_overlaps (rsp_overlaps),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic wide_t coord(tri_flat_t f, int n);
      logic [CW-1:0] x;
      x = f[n*CW +: CW];
      return $signed({{(128-CW){x[CW-1]}}, x});
   endfunction

   function automatic wide_t wabs(wide_t a);
      return (a < 0) ? -a : a;
   endfunction

   function automatic bit predict_overlap(tri_flat_t f);
      wide_t v[3][3];
      wide_t ed[3][3];
      wide_t h[3];
      wide_t nrm[3];
      wide_t p, lo, hi, rad, hs, dmin, dmax;
      int j, k;
      bit sep;
      sep = 1'b0;
      for (int c = 0; c < 3; c++)
         h[c] = $signed({105'd0, half_size[c]});
      for (int t = 0; t < 3; t++)
         for (int c = 0; c < 3; c++)
            v[t][c] = coord(f, t*3 + c) - coord(f, 9 + c);
      for (int c = 0; c < 3; c++) begin
         ed[0][c] = v[1][c] - v[0][c];
         ed[1][c] = v[2][c] - v[1][c];
         ed[2][c] = v[0][c] - v[2][c];
      end
      for (int t = 0; t < 3; t++)
         for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            for (int s = 0; s < 3; s++) begin
               p = ed[t][k] * v[s][j] - ed[t][j] * v[s][k];
               if (s == 0 || p < lo) lo = (s == 0) ? p : p;
               if (s == 0) hi = p;
               else if (p > hi) hi = p;
            end
            rad = wabs(ed[t][k]) * h[j] + wabs(ed[t][j]) * h[k];
            if (lo > rad || hi < -rad) sep = 1'b1;
         end
      for (int c = 0; c < 3; c++) begin
         lo = v[0][c];
         hi = v[0][c];
         for (int s = 1; s < 3; s++) begin
            if (v[s][c] < lo) lo = v[s][c];
            if (v[s][c] > hi) hi = v[s][c];
         end
         if (lo > h[c] || hi < -h[c]) sep = 1'b1;
      end
      for (int c = 0; c < 3; c++) begin
         j = (c + 1) % 3;
         k = (c + 2) % 3;
         nrm[c] = ed[0][j] * ed[1][k] - ed[0][k] * ed[1][j];
      end
      dmin = 0;
      dmax = 0;
      for (int c = 0; c < 3; c++) begin
         hs = (nrm[c] > 0) ? h[c] : -h[c];
         dmin = dmin + nrm[c] * (-hs - v[0][c]);
         dmax = dmax + nrm[c] * (hs - v[0][c]);
      end
      if (dmin > 0 || dmax < 0) sep = 1'b1;
      return !sep;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("triangle_box_overlap_test_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_result(rsp_overlaps);

   task automatic idle_gap();
      if (!no_idle && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_request(tri_flat_t f);
      bit stalled;
      idle_gap();
      start      <= 1'b1;
      req_fields <= f;
      do begin
         @(negedge clock);
         stalled = busy;
         @(posedge clock);
      end while (stalled);
      board.note_request(predict_overlap(f));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.expected_overlaps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_half(logic [CSR_IDX_WIDTH-1:0] idx, half_type value);
      bit held;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         held = !csr_ready;
         @(posedge clock);
      end while (held);
      csr_valid <= 1'b0;
      if (idx == CSR_HALF_X) half_size[0] = value;
      else if (idx == CSR_HALF_Y) half_size[1] = value;
      else if (idx == CSR_HALF_Z) half_size[2] = value;
      @(posedge clock);
   endtask

   task automatic set_box(half_type hx, half_type hy, half_type hz);
      write_half(CSR_HALF_X, hx);
      write_half(CSR_HALF_Y, hy);
      write_half(CSR_HALF_Z, hz);
   endtask

   function automatic tri_flat_t uniform_tri();
      tri_flat_t f;
      for (int n = 0; n < NFIELD; n++) f[n*CW +: CW] = CW'($urandom);
      return f;
   endfunction

   // vertices scattered around the centre at a random scale
   function automatic tri_flat_t near_tri();
      tri_flat_t f;
      logic [CW-1:0] ctr[3];
      int sh, span;
      sh = $urandom_range(2, 22);
      for (int c = 0; c < 3; c++) begin
         ctr[c] = CW'($urandom);
         f[(9 + c)*CW +: CW] = ctr[c];
      end
      for (int t = 0; t < 3; t++)
         for (int c = 0; c < 3; c++) begin
            span = 1 << sh;
            f[(t*3 + c)*CW +: CW] =
               CW'(ctr[c] + ($signed($urandom_range(0, 2*span)) - span));
         end
      return f;
   endfunction

   function automatic tri_flat_t make_tri(int v0x, int v0y, int v0z, int v1x, int v1y,
                                          int v1z, int v2x, int v2y, int v2z,
                                          int cx, int cy, int cz);
      tri_flat_t f;
      int a[12];
      a = '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, cx, cy, cz};
      for (int n = 0; n < NFIELD; n++) f[n*CW +: CW] = CW'(a[n]);
      return f;
   endfunction

   task automatic random_phase(int count);
      for (int n = 0; n < count; n++) begin
         no_idle = (n >= count/2 && n < count/2 + 60);
         if ($urandom_range(0, 9) == 0) send_request(uniform_tri());
         else send_request(near_tri());
      end
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      tri_flat_t all_min, all_max;
      board       = new();
      no_idle     = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_HALF_X;
      csr_wdata   = '0;
      req_fields  = '0;
      for (int c = 0; c < 3; c++) half_size[c] = HALF_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < NFIELD; n++) begin
         all_min[n*CW +: CW] = {1'b1, {(CW-1){1'b0}}};
         all_max[n*CW +: CW] = {1'b0, {(CW-1){1'b1}}};
      end
      // directed: reset box of half 0.5 (2048)
      send_request('0);
      send_request(all_min);
      send_request(all_max);
      send_request(all_min ^ {NFIELD*CW{1'b1}});
      send_request(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0));
      send_request(make_tri(2048, 0, 0, 9000, 0, 0, 9000, 500, 0, 0, 0, 0));
      send_request(make_tri(2049, 0, 0, 9000, 0, 0, 9000, 500, 0, 0, 0, 0));
      send_request(make_tri(-5000, -5000, 0, 5000, -5000, 0, 0, 5000, 0, 0, 0, 2048));
      send_request(make_tri(-5000, -5000, 0, 5000, -5000, 0, 0, 5000, 0, 0, 0, 2049));
      send_request(make_tri(100, 100, 100, 100, 100, 100, 300, 200, 100, 0, 0, 0));
      send_request(make_tri(0, 0, 0, 1000, 1000, 1000, 2000, 2000, 2000, 0, 0, 0));
      send_request(make_tri(3000, 0, 3000, 0, 3000, 3000, 3000, 3000, 0, 0, 0, 0));
      send_request(make_tri(4000, 0, 4000, 0, 4000, 4000, 4000, 4000, 0, 0, 0, 0));
      send_request(make_tri(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                            8388607, -8388608, 0, 0, 0, 0));
      send_request(make_tri(-8388608, 0, 0, 0, -8388608, 0, 0, 0, -8388608,
                            8388607, 8388607, 8388607));
      drain();
      random_phase(250);

      set_box('0, '0, '0);
      send_request('0);
      send_request(make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 0));
      send_request(make_tri(1, 0, 0, 4096, 0, 0, 0, 4096, 0, 4096, 0, 0));
      random_phase(250);

      set_box({HALF_WIDTH{1'b1}}, {HALF_WIDTH{1'b1}}, {HALF_WIDTH{1'b1}});
      send_request(all_min);
      send_request(all_max);
      random_phase(250);

      write_half(2'd3, HALF_WIDTH'($urandom));
      set_box(HALF_WIDTH'($urandom_range(0, 4096)), HALF_WIDTH'($urandom),
              HALF_WIDTH'($urandom_range(0, 255)));
      random_phase(250);

      set_box(HALF_WIDTH'($urandom), HALF_WIDTH'($urandom), HALF_WIDTH'($urandom));
      random_phase(250);

      set_box(HALF_WIDTH'($urandom_range(1, 65536)), HALF_WIDTH'($urandom_range(1, 65536)),
              HALF_WIDTH'($urandom_range(1, 65536)));
      random_phase(250);

      write_half(2'd3, '0);
      set_box(HALF_WIDTH'($urandom_range(0, 1 << 16)), {HALF_WIDTH{1'b1}}, '0);
      random_phase(200);

      if (board.failures == 0 && board.expected_overlaps.size() == 0)
         $display("triangle_box_overlap_test_top regression: pass");
      else
         $display("triangle_box_overlap_test_top regression: fail");
      $finish;
   end

endmodule
